// ===== rtl/bufu_pkg.sv =====
// shared constants and types for the buffered uart fifo front end
`default_nettype none

package bufu_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int BYTE_W     = 8;
  localparam int CMD_W      = 2;
  localparam int LEVEL_W    = 5;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam cmd_t CMD_PUT     = 2'd0;
  localparam cmd_t CMD_GET     = 2'd1;
  localparam cmd_t CMD_TX_DONE = 2'd2;
  localparam cmd_t CMD_RX_BYTE = 2'd3;

  // requests from the command decode to one ring fifo
  typedef struct packed {
    logic  push;
    logic  pop;
    byte_t push_data;
  } fifo_ctl_t;

  // ring fifo status back to the command decode
  typedef struct packed {
    logic   full;
    logic   empty;
    byte_t  head_data;
    level_t level_nxt;
  } fifo_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bufu_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none

module bufu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bufu_fifo.sv =====
// ring fifo: pointers, fill count, storage ram and head prefetch
`default_nettype none

module bufu_fifo import bufu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fifo_ctl_t ctl,
  output fifo_sts_t      sts
);

  ptr_t  head_r, head_nxt;
  ptr_t  tail_r, tail_nxt;
  cnt_t  fill_r, fill_nxt;
  logic  byp_r, byp_nxt;
  byte_t byp_data_r;
  byte_t ram_rdata;

  function automatic ptr_t wrap_inc(input ptr_t p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    head_nxt = ctl.pop ? wrap_inc(head_r) : head_r;
    tail_nxt = ctl.push ? wrap_inc(tail_r) : tail_r;
    fill_nxt = fill_r;
    if (ctl.push && !ctl.pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      fill_nxt = fill_r - 1'b1;
    end
    // a write to the entry being prefetched must win over the old ram word
    byp_nxt = ctl.push && (tail_r == head_nxt);
  end

  // the read port always fetches the entry at the next head
  bufu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail_r),
    .wdata (ctl.push_data),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      byp_r  <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= ctl.push_data;
  end

  always_comb begin
    sts.full      = (fill_r == CNT_W'(FIFO_DEPTH));
    sts.empty     = (fill_r == '0);
    sts.head_data = byp_r ? byp_data_r : ram_rdata;
    sts.level_nxt = LEVEL_W'(fill_nxt);
  end

endmodule

`default_nettype wire

// ===== rtl/buffered_uart_tx_rx_fifos_core.sv =====
// buffered uart front end: transmit and receive ring fifos with busy flag
//
// input channel: one beat per command (put byte, get byte, transmit done,
// byte received) with its data byte. output channel: one result beat per
// command carrying the byte handed to the transmit line, the byte read from
// the receive fifo, the put/drop flags, the busy flag and both fill levels.
// a command beat is registered on acceptance, decoded against the fifo state
// once the output register is free, and its result lands in the output
// register at the end of the decode cycle; one beat per cycle is sustained
// while out_stall stays low. each fifo keeps its head byte prefetched from
// its ram, so a pop does not wait on a ram read.
// reset clears pointers, fill counts, the busy flag and both pipeline valid
// bits; fifo storage is not cleared and needs no sweep.
// when the receiver holds out_stall, the result stays put, the registered
// command waits, and in_stall rises once that command cannot move on.
`default_nettype none

module buffered_uart_tx_rx_fifos_core import bufu_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire cmd_t   in_command,
  input  wire byte_t  in_data_byte,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic        out_line_valid,
  output byte_t       out_line_byte,
  output logic        out_read_valid,
  output byte_t       out_read_byte,
  output logic        out_put_accepted,
  output logic        out_rx_dropped,
  output logic        out_busy_flag,
  output level_t      out_tx_level,
  output level_t      out_rx_level
);

  logic  s0_valid_r, s0_valid_nxt;
  cmd_t  s0_cmd_r;
  byte_t s0_data_r;

  logic  out_valid_r, out_valid_nxt;
  logic  sending_r, sending_nxt;
  logic  out_free, adv, in_take;

  fifo_ctl_t tx_ctl, rx_ctl;
  fifo_sts_t tx_sts, rx_sts;

  logic  line_valid, read_valid, put_ok, dropped;
  byte_t line_byte, read_byte;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s0_valid_r && out_free;
  assign in_stall = s0_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_take) begin
      s0_valid_nxt = 1'b1;
    end else if (adv) begin
      s0_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // command decode against the current fifo state
  always_comb begin
    tx_ctl      = '0;
    rx_ctl      = '0;
    tx_ctl.push_data = s0_data_r;
    rx_ctl.push_data = s0_data_r;
    sending_nxt = sending_r;
    line_valid  = 1'b0;
    line_byte   = '0;
    read_valid  = 1'b0;
    read_byte   = '0;
    put_ok      = 1'b0;
    dropped     = 1'b0;
    if (adv) begin
      case (s0_cmd_r)
        CMD_PUT: begin
          if (!tx_sts.full) begin
            put_ok = 1'b1;
            if (sending_r) begin
              tx_ctl.push = 1'b1;
            end else begin
              // idle line takes the byte directly
              sending_nxt = 1'b1;
              line_valid  = 1'b1;
              line_byte   = s0_data_r;
            end
          end
        end
        CMD_GET: begin
          if (!rx_sts.empty) begin
            read_valid = 1'b1;
            read_byte  = rx_sts.head_data;
            rx_ctl.pop = 1'b1;
          end
        end
        CMD_TX_DONE: begin
          if (!tx_sts.empty) begin
            line_valid = 1'b1;
            line_byte  = tx_sts.head_data;
            tx_ctl.pop = 1'b1;
          end else begin
            sending_nxt = 1'b0;
          end
        end
        CMD_RX_BYTE: begin
          if (!rx_sts.full) begin
            rx_ctl.push = 1'b1;
          end else begin
            dropped = 1'b1;
          end
        end
        default: begin
          sending_nxt = sending_r;
        end
      endcase
    end
  end

  bufu_fifo u_tx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tx_ctl),
    .sts   (tx_sts)
  );

  bufu_fifo u_rx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rx_ctl),
    .sts   (rx_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sending_r   <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sending_r   <= sending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_cmd_r  <= in_command;
      s0_data_r <= in_data_byte;
    end
    if (adv) begin
      out_line_valid   <= line_valid;
      out_line_byte    <= line_byte;
      out_read_valid   <= read_valid;
      out_read_byte    <= read_byte;
      out_put_accepted <= put_ok;
      out_rx_dropped   <= dropped;
      out_busy_flag    <= sending_nxt;
      out_tx_level     <= tx_sts.level_nxt;
      out_rx_level     <= rx_sts.level_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/bufu_chk.sv =====
// port-level checks for the buffered uart front end, bound to the top level
`default_nettype none

module bufu_chk import bufu_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_valid,
  input wire logic   in_stall,
  input wire cmd_t   in_command,
  input wire byte_t  in_data_byte,
  input wire logic   out_valid,
  input wire logic   out_stall,
  input wire logic   out_line_valid,
  input wire byte_t  out_line_byte,
  input wire logic   out_read_valid,
  input wire byte_t  out_read_byte,
  input wire logic   out_put_accepted,
  input wire logic   out_rx_dropped,
  input wire logic   out_busy_flag,
  input wire level_t out_tx_level,
  input wire level_t out_rx_level
);

  // a stalled command beat keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_command) && $stable(in_data_byte))
    else $error("command beat changed while stalled");

  // a stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_valid || out_line_byte == '0) &&
                  (out_read_valid || out_read_byte == '0))
    else $error("byte nonzero without its valid flag");

  // queued transmit bytes only exist while the line is busy
  a_tx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tx_level != '0 || out_put_accepted) |-> out_busy_flag)
    else $error("transmit bytes pending with line idle");

  // a byte is only dropped when the receive fifo is full
  a_rx_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_dropped |-> out_rx_level == LEVEL_W'(FIFO_DEPTH))
    else $error("received byte dropped with room left");

endmodule

bind buffered_uart_tx_rx_fifos_core bufu_chk u_bufu_chk (.*);

`default_nettype wire
